>>> rtl/core/mct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_pkg
// Types and codes shared by the multiset count table and its checker.
// ----------------------------------------------------------------------------
package mct_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 32;
    localparam int TOTAL_W = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // operation codes; the unused code behaves as a query
    localparam logic [1:0] FUNC_PUT    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_AMOUNT = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } t_entry;

endpackage

>>> rtl/core/multiset_count_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiset_count_table
// Bounded multiset of signed 32-bit keys with per-key occurrence counts,
// held in one single-port table memory with a registered read.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------
//  command   | start, busy (transfer when | i_func, i_key, i_amount
//            | start high and busy low)   |
//  result    | o_valid, one-cycle strobe  | o_status, o_key_count,
//            |                            | o_distinct_keys, o_single_keys
//
// From transfer to the next possible transfer, every command streams every
// slot through the one memory port (S_SCAN), waits for the last read to land
// (S_TAIL), does at most one write (S_EXEC), and then shows the strobe,
// during which the next command is already taken.
// After reset the block sweeps through the memory to mark all
// slots free; busy stays high until the sweep ends.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module multiset_count_table #(
    parameter int ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_func,
    input  logic signed [31:0]  i_key,
    input  logic [31:0]         i_amount,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [31:0]         o_key_count,
    output logic [6:0]          o_distinct_keys,
    output logic [6:0]          o_single_keys
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int OW = mct_pkg::TOTAL_W;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    mct_pkg::t_entry r_mem [ENTRIES];

    mct_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_rd_vld;
    mct_pkg::t_entry r_rd_data;

    logic [1:0]                   r_func, n_func;
    logic [mct_pkg::KEY_W-1:0]    r_key, n_key;
    logic [mct_pkg::COUNT_W-1:0]  r_amount, n_amount;

    logic                         r_hit, n_hit;
    logic [AW-1:0]                r_hit_idx, n_hit_idx;
    logic [mct_pkg::COUNT_W-1:0]  r_hit_cnt, n_hit_cnt;
    logic                         r_free, n_free;
    logic [AW-1:0]                r_free_idx, n_free_idx;

    logic [CW-1:0]  r_used_total, n_used_total;
    logic [CW-1:0]  r_singles, n_singles;

    logic                         r_valid, n_valid;
    mct_pkg::t_status             r_status, n_status;
    logic [mct_pkg::COUNT_W-1:0]  r_count, n_count;

    logic                         w_we;
    logic [AW-1:0]                w_mem_addr;
    mct_pkg::t_entry              w_wdata;
    logic [mct_pkg::COUNT_W-1:0]  w_now;
    logic                         w_track;

    logic [CW+OW-1:0] w_dist_ext;
    logic [CW+OW-1:0] w_single_ext;

    // table memory: one port, read data registered
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_mem_addr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mct_pkg::S_CLEAR;
            r_addr       <= '0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_free       <= 1'b0;
            r_used_total <= '0;
            r_singles    <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_rd_vld     <= (r_state == mct_pkg::S_SCAN);
            r_hit        <= n_hit;
            r_free       <= n_free;
            r_used_total <= n_used_total;
            r_singles    <= n_singles;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_amount   <= n_amount;
        r_hit_idx  <= n_hit_idx;
        r_hit_cnt  <= n_hit_cnt;
        r_free_idx <= n_free_idx;
        r_status   <= n_status;
        r_count    <= n_count;
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_func       = r_func;
        n_key        = r_key;
        n_amount     = r_amount;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_cnt    = r_hit_cnt;
        n_free       = r_free;
        n_free_idx   = r_free_idx;
        n_used_total = r_used_total;
        n_singles    = r_singles;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_count      = r_count;
        w_we         = 1'b0;
        w_mem_addr   = r_addr;
        w_wdata      = '0;
        w_now        = r_hit_cnt;
        w_track      = 1'b0;

        // record the first matching slot and the lowest free slot
        if (r_rd_vld) begin
            if (r_rd_data.used && (r_rd_data.key == r_key) && !r_hit) begin
                n_hit     = 1'b1;
                n_hit_idx = r_addr - AW'(1);
                n_hit_cnt = r_rd_data.count;
            end
            if (!r_rd_data.used && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_addr - AW'(1);
            end
        end
        // the last slot lands while the address has wrapped to zero
        if (r_rd_vld && r_state == mct_pkg::S_TAIL) begin
            if (r_rd_data.used && (r_rd_data.key == r_key) && !r_hit) begin
                n_hit_idx = LAST;
            end
            if (!r_rd_data.used && !r_free) begin
                n_free_idx = LAST;
            end
        end

        case (r_state)
            mct_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = '0;
                n_addr  = r_addr + AW'(1);
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = mct_pkg::S_IDLE;
                end
            end
            mct_pkg::S_IDLE: begin
                if (start) begin
                    n_state  = mct_pkg::S_SCAN;
                    n_addr   = '0;
                    n_func   = i_func;
                    n_key    = i_key;
                    n_amount = i_amount;
                    n_hit    = 1'b0;
                    n_free   = 1'b0;
                end
            end
            mct_pkg::S_SCAN: begin
                n_addr = r_addr + AW'(1);
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = mct_pkg::S_TAIL;
                end
            end
            mct_pkg::S_TAIL: begin
                n_state = mct_pkg::S_EXEC;
            end
            mct_pkg::S_EXEC: begin
                n_state    = mct_pkg::S_IDLE;
                n_valid    = 1'b1;
                n_status   = mct_pkg::ST_OK;
                n_count    = '0;
                w_mem_addr = r_hit ? r_hit_idx : r_free_idx;
                case (r_func)
                    mct_pkg::FUNC_PUT: begin
                        if (r_hit) begin
                            w_now   = (r_hit_cnt == mct_pkg::COUNT_MAX) ?
                                      mct_pkg::COUNT_MAX : r_hit_cnt + 32'd1;
                            w_track = 1'b1;
                            w_we    = 1'b1;
                            w_wdata = '{used: 1'b1, key: r_key, count: w_now};
                            n_count = w_now;
                        end else if (r_free) begin
                            w_we         = 1'b1;
                            w_wdata      = '{used: 1'b1, key: r_key, count: 32'd1};
                            n_used_total = r_used_total + CW'(1);
                            n_singles    = r_singles + CW'(1);
                            n_count      = 32'd1;
                        end else begin
                            n_status = mct_pkg::ST_FULL;
                        end
                    end
                    mct_pkg::FUNC_REMOVE: begin
                        if (!r_hit) begin
                            n_status = mct_pkg::ST_ABSENT;
                        end else if (r_amount > r_hit_cnt) begin
                            n_status = mct_pkg::ST_AMOUNT;
                            n_count  = r_hit_cnt;
                        end else begin
                            w_now   = r_hit_cnt - r_amount;
                            w_track = 1'b1;
                            w_we    = 1'b1;
                            n_count = w_now;
                            if (w_now == '0) begin
                                w_wdata      = '{used: 1'b0, key: r_key, count: '0};
                                n_used_total = r_used_total - CW'(1);
                            end else begin
                                w_wdata = '{used: 1'b1, key: r_key, count: w_now};
                            end
                        end
                    end
                    default: begin
                        n_count = r_hit ? r_hit_cnt : '0;
                    end
                endcase
                // adjust the single-occurrence total on a count change
                if (w_track) begin
                    if (w_now == 32'd1 && r_hit_cnt != 32'd1) begin
                        n_singles = r_singles + CW'(1);
                    end else if (w_now != 32'd1 && r_hit_cnt == 32'd1) begin
                        n_singles = r_singles - CW'(1);
                    end
                end
            end
            default: begin
                n_state = mct_pkg::S_IDLE;
            end
        endcase
    end

    assign w_dist_ext   = {{OW{1'b0}}, r_used_total};
    assign w_single_ext = {{OW{1'b0}}, r_singles};

    assign busy            = (r_state != mct_pkg::S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_key_count     = r_count;
    assign o_distinct_keys = w_dist_ext[OW-1:0];
    assign o_single_keys   = w_single_ext[OW-1:0];

endmodule

>>> rtl/core/mct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_checker
// Port-level checks on command and result timing and on zero error counts.
// ----------------------------------------------------------------------------
module mct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [31:0] o_key_count
);

    // a transfer makes the block busy in the next cycle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after a command transfer");

    // each result follows a busy cycle
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    // one result per command: the strobe is never held high
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // absent key or full table always reports a zero count
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mct_pkg::ST_ABSENT || o_status == mct_pkg::ST_FULL))
        |-> (o_key_count == '0))
        else $error("nonzero count with absent or full status");

endmodule

bind multiset_count_table mct_checker u_mct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_key_count (o_key_count)
);

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multiset count table. A directed sequence
// covers the extremes of key and amount, every operation and the absent-key
// and amount error paths. Random phases then fill the table from a key pool
// until it is full and churn it with puts, removes and queries, each result
// checked field by field against its typed row or a behavioral table copy.
// ----------------------------------------------------------------------------
module tb;
    import mct_pkg::*;

    localparam int ENTRIES = 64;
    localparam int POOL    = 68;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] key_count;
        logic [TOTAL_W-1:0] distinct;
        logic [TOTAL_W-1:0] single;
    } t_result;

    typedef struct packed {
        logic [1:0]         func;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] amount;
        logic               typed;
        t_result            want;
    } t_row;

    // rows with typed == 1 carry their own expected result
    localparam t_row DIRECTED [0:19] = '{
        '{FUNC_QUERY,  32'h0000_0000, 32'd0,         1'b1, '{ST_OK,     32'd0, 7'd0, 7'd0}},
        '{FUNC_REMOVE, 32'h8000_0000, 32'd1,         1'b1, '{ST_ABSENT, 32'd0, 7'd0, 7'd0}},
        '{FUNC_PUT,    32'h8000_0000, 32'd0,         1'b1, '{ST_OK,     32'd1, 7'd1, 7'd1}},
        '{FUNC_PUT,    32'h7FFF_FFFF, 32'd0,         1'b1, '{ST_OK,     32'd1, 7'd2, 7'd2}},
        '{FUNC_PUT,    32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK,     32'd2, 7'd2, 7'd1}},
        '{FUNC_REMOVE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_AMOUNT, 32'd2, 7'd2, 7'd1}},
        '{FUNC_REMOVE, 32'h7FFF_FFFF, 32'd0,         1'b1, '{ST_OK,     32'd2, 7'd2, 7'd1}},
        '{2'd3,        32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK,     32'd2, 7'd2, 7'd1}},
        '{FUNC_QUERY,  32'h8000_0000, 32'd0,         1'b1, '{ST_OK,     32'd1, 7'd2, 7'd1}},
        '{FUNC_PUT,    32'hFFFF_FFFF, 32'd0,         1'b1, '{ST_OK,     32'd1, 7'd3, 7'd2}},
        '{FUNC_PUT,    32'h0000_0000, 32'd0,         1'b1, '{ST_OK,     32'd1, 7'd4, 7'd3}},
        '{FUNC_REMOVE, 32'h7FFF_FFFF, 32'd1,         1'b1, '{ST_OK,     32'd1, 7'd4, 7'd4}},
        '{FUNC_REMOVE, 32'h8000_0000, 32'd1,         1'b1, '{ST_OK,     32'd0, 7'd3, 7'd3}},
        '{FUNC_QUERY,  32'h8000_0000, 32'd0,         1'b1, '{ST_OK,     32'd0, 7'd3, 7'd3}},
        '{FUNC_PUT,    32'h8000_0000, 32'd0,         1'b1, '{ST_OK,     32'd1, 7'd4, 7'd4}},
        '{FUNC_REMOVE, 32'h0000_0000, 32'd2,         1'b1, '{ST_AMOUNT, 32'd1, 7'd4, 7'd4}},
        '{FUNC_PUT,    32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '{ST_OK,     32'd0, 7'd0, 7'd0}},
        '{FUNC_PUT,    32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '{ST_OK,     32'd0, 7'd0, 7'd0}},
        '{FUNC_REMOVE, 32'h5555_5555, 32'h8000_0000, 1'b0, '{ST_OK,     32'd0, 7'd0, 7'd0}},
        '{FUNC_QUERY,  32'hAAAA_AAAA, 32'd0,         1'b0, '{ST_OK,     32'd0, 7'd0, 7'd0}}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_func;
    logic signed [31:0] i_key;
    logic [31:0]        i_amount;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [31:0]        o_key_count;
    logic [6:0]         o_distinct_keys;
    logic [6:0]         o_single_keys;

    // bench copy of the table
    logic [KEY_W-1:0]   slot_key   [ENTRIES];
    logic [COUNT_W-1:0] slot_count [ENTRIES];
    logic               slot_used  [ENTRIES];
    int                 keys_held;
    int                 keys_single;

    t_result awaited_results[$];
    int      mismatches;
    int      commands_sent;
    int      results_seen;
    int      status_seen [4];
    int      peak_keys;

    multiset_count_table #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_key          (i_key),
        .i_amount       (i_amount),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_key_count    (o_key_count),
        .o_distinct_keys(o_distinct_keys),
        .o_single_keys  (o_single_keys)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // apply one operation to the bench table and return the result it gives
    function automatic t_result multiset_apply(logic [1:0] func, logic [KEY_W-1:0] key,
                                               logic [COUNT_W-1:0] amount);
        t_result            r;
        int                 hit;
        int                 spare;
        logic [COUNT_W-1:0] was;
        logic [COUNT_W-1:0] now;
        r.status    = ST_OK;
        r.key_count = '0;
        hit   = -1;
        spare = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
            if (spare < 0 && !slot_used[i]) spare = i;
        end
        if (func == FUNC_PUT) begin
            if (hit < 0) begin
                if (spare < 0) begin
                    r.status = ST_FULL;
                end else begin
                    slot_used[spare]  = 1'b1;
                    slot_key[spare]   = key;
                    slot_count[spare] = 1;
                    keys_held++;
                    keys_single++;
                    r.key_count = 1;
                end
            end else begin
                was = slot_count[hit];
                now = (was == COUNT_MAX) ? was : was + 1;
                keys_single += int'(now == 1) - int'(was == 1);
                slot_count[hit] = now;
                r.key_count = now;
            end
        end else if (func == FUNC_REMOVE) begin
            if (hit < 0) begin
                r.status = ST_ABSENT;
            end else begin
                was = slot_count[hit];
                if (amount > was) begin
                    r.status    = ST_AMOUNT;
                    r.key_count = was;
                end else begin
                    now = was - amount;
                    keys_single += int'(now == 1) - int'(was == 1);
                    slot_count[hit] = now;
                    if (now == 0) begin
                        slot_used[hit] = 1'b0;
                        keys_held--;
                    end
                    r.key_count = now;
                end
            end
        end else if (hit >= 0) begin
            r.key_count = slot_count[hit];
        end
        r.distinct = keys_held[TOTAL_W-1:0];
        r.single   = keys_single[TOTAL_W-1:0];
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] held_count(logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && slot_key[i] == key) return slot_count[i];
        end
        return '0;
    endfunction

    task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] result %0d: %s got 0x%08h, want 0x%08h",
                 $realtime, results_seen, field, got, want);
        mismatches++;
    endtask

    // hold start high until the command transfers, then log its expectation
    task automatic issue(t_row r);
        t_result pred;
        start    <= 1'b1;
        i_func   <= r.func;
        i_key    <= r.key;
        i_amount <= r.amount;
        do @(posedge i_clk); while (busy);
        pred = multiset_apply(r.func, r.key, r.amount);
        awaited_results.insert(awaited_results.size(), r.typed ? r.want : pred);
        commands_sent++;
    endtask

    // fill the table from a fresh key pool, then churn it
    task automatic run_phase(int gap_pct, int items);
        logic [KEY_W-1:0] pool [POOL];
        logic [KEY_W-1:0] tmp;
        t_row             r;
        int               j;
        int               pick;
        logic [COUNT_W-1:0] have;
        for (int i = 0; i < POOL; i++) pool[i] = $urandom;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        for (int i = POOL - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            tmp     = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        for (int n = 0; n < items; n++) begin
            r        = '0;
            r.key    = ($urandom_range(9) == 0) ? 32'($urandom) : pool[$urandom_range(POOL - 1)];
            r.amount = $urandom;
            if (n < POOL) begin
                r.func = FUNC_PUT;
                r.key  = pool[n];
            end else begin
                pick = $urandom_range(99);
                have = held_count(r.key);
                if (pick < 40) begin
                    r.func = FUNC_PUT;
                end else if (pick < 75) begin
                    r.func = FUNC_REMOVE;
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4: r.amount = have;
                        5, 6:          r.amount = $urandom_range(have);
                        7:             r.amount = have + 1;
                        8:             r.amount = '0;
                        default:       r.amount = $urandom;
                    endcase
                end else if (pick < 92) begin
                    r.func = FUNC_QUERY;
                end else begin
                    r.func = 2'($urandom_range(3));
                end
            end
            // idle gaps long enough to land on any cycle of a command
            if ($urandom_range(99) < gap_pct) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 90)) @(posedge i_clk);
            end
            issue(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch("unexpected strobe", 32'(o_status), 32'hFFFF_FFFF);
            end else begin
                t_result w;
                w = awaited_results.pop_front();
                if (o_status != w.status)
                    flag_mismatch("status", 32'(o_status), 32'(w.status));
                if (o_key_count != w.key_count)
                    flag_mismatch("key_count", o_key_count, w.key_count);
                if (o_distinct_keys != w.distinct)
                    flag_mismatch("distinct_keys", 32'(o_distinct_keys), 32'(w.distinct));
                if (o_single_keys != w.single)
                    flag_mismatch("single_keys", 32'(o_single_keys), 32'(w.single));
            end
            status_seen[o_status]++;
            if (o_distinct_keys > peak_keys) peak_keys = o_distinct_keys;
            results_seen++;
        end
    end

    initial begin
        #8_000_000;
        $display("multiset_count_table: mismatch");
        $finish;
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_func       <= FUNC_QUERY;
        i_key        <= '0;
        i_amount     <= '0;
        mismatches    = 0;
        commands_sent = 0;
        results_seen  = 0;
        peak_keys     = 0;
        keys_held     = 0;
        keys_single   = 0;
        for (int i = 0; i < 4; i++) status_seen[i] = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_count[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 20; i++) issue(DIRECTED[i]);
        run_phase(11, 277);
        run_phase(73, 277);
        run_phase(0, 276);
        start <= 1'b0;

        while (awaited_results.size() != 0) @(posedge i_clk);
        // catch any stray strobe after the last expected one
        repeat (ENTRIES + 8) @(posedge i_clk);

        $display("%0d commands, %0d results; peak of %0d distinct keys",
                 commands_sent, results_seen, peak_keys);
        $display("status ok %0d, amount %0d, absent %0d, full %0d",
                 status_seen[ST_OK], status_seen[ST_AMOUNT],
                 status_seen[ST_ABSENT], status_seen[ST_FULL]);
        if (mismatches == 0) begin
            $display("multiset_count_table: match");
        end else begin
            $display("multiset_count_table: mismatch");
        end
        $finish;
    end

endmodule
